[sv/btm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the buddy tree bitmap marker.
// No dependencies; imported by the top level.
package btm_pkg;

  // Tree depth and the bit store derived from it
  localparam int MAX_LEVELS = 10;
  localparam int STORE_SIZE = (1 << MAX_LEVELS) - 1;
  // Node indices are 10 bits wide, so nothing beyond 1023 is ever addressed
  localparam int STORE_LIM  = (STORE_SIZE < 1023) ? STORE_SIZE : 1023;

  // Bit store packed into rows of 32 bits
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;
  localparam int ROWS   = (STORE_LIM + WORD_W - 1) / WORD_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Field widths
  localparam int NODE_W   = 10;
  localparam int IDX_W    = 11;
  localparam int REQ_W    = 24;
  localparam int BUCKET_W = 25;
  localparam int CFG_W    = 21;

  localparam logic [BUCKET_W-1:0] BUCKET_MAX  = {BUCKET_W{1'b1}};
  localparam logic [BUCKET_W-1:0] BUCKET_HALF = BUCKET_MAX >> 1;
  localparam logic signed [4:0]   LEVEL_MIN   = -5'sd16;
  localparam logic [IDX_W-1:0]    IDX_LIM     = IDX_W'(STORE_LIM);
  localparam logic [IDX_W-1:0]    HI_CAP      = IDX_W'(1023);

  // Configuration register reset values
  localparam logic [4:0]       RST_LEVEL_COUNT = 5'd10;
  localparam logic [3:0]       RST_START_LEVEL = 4'd9;
  localparam logic [20:0]      RST_MIN_BUCKET  = 21'd16;
  localparam logic [NODE_W-1:0] RST_NODE_LIMIT = 10'd1023;

  typedef enum logic [1:0] {
    CFG_LEVEL_COUNT = 2'd0,
    CFG_START_LEVEL = 2'd1,
    CFG_MIN_BUCKET  = 2'd2,
    CFG_NODE_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_ANCESTORS = 2'd0,
    CMD_SUBTREE   = 2'd1,
    CMD_LEVEL     = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ANC_RD,
    ST_ANC_WR,
    ST_SUB_LEVEL,
    ST_SUB_RD,
    ST_SUB_WR,
    ST_LVL,
    ST_BIT_RD,
    ST_BIT_GET,
    ST_DONE
  } state_t;

endpackage

[sv/btm_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module btm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, read the addressed row every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/buddy_tree_bitmap_marker_top.sv]
`timescale 1ns / 1ps
// Top level of the buddy tree bitmap marker: command sequencer around a row RAM.
// Depends on btm_pkg and btm_ram.
//
// Usage: one command per beat on the item channel (item_valid / item_stall);
// one result beat per command on the result channel (res_valid / res_stall).
// The tree bitmap lives in a RAM of 32-bit rows, written by read-modify-write.
// Work per command, from accept to result register:
//   read bit         one read of the node's row
//   mark ancestors   one read-modify-write per node on the path to the root
//   mark subtree     one read-modify-write per RAM row touched on each level
//                    visited, through the single RAM port
//   choose level     steps taken (at most level_count)
// One command is in work at a time; the next is taken in the cycle after the
// result has moved to the output register, even if the receiver still stalls it.
// A stalled result holds until taken; the sequencer waits only if a second
// result is ready before the first is taken.
// Reset: config registers return to their reset values, then a clearing
// pass writes zero to every row while item_stall stays high.
// Configuration writes (cfg_valid / cfg_ready) are taken at any time.
module buddy_tree_bitmap_marker_top
  import btm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // Item channel
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [1:0]              command,
  input  logic [NODE_W-1:0]       node,
  input  logic                    status,
  input  logic [REQ_W-1:0]        request_size,
  // Result channel
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic signed [4:0]       level,
  output logic                    bit_value,
  output logic                    done_res
);

  state_t state, state_next;

  // Configuration registers
  logic [4:0]        level_count;
  logic [3:0]        start_level;
  logic [20:0]       min_bucket_size;
  logic [NODE_W-1:0] node_limit;

  // Latched item
  cmd_t             cmd;
  logic             status_q;
  logic [NODE_W-1:0] node_q;
  logic [REQ_W-1:0] req;

  // Walk registers
  logic [IDX_W-1:0]    cur;
  logic [IDX_W-1:0]    lo;
  logic [IDX_W-1:0]    hi;
  logic [IDX_W-1:0]    seg_end;
  logic [ROW_AW-1:0]   row;
  logic [ROW_AW-1:0]   clr_row;
  logic [BUCKET_W-1:0] bucket;
  logic signed [4:0]   lvl;
  logic [4:0]          step;
  logic                bit_q;

  // RAM port
  logic [ROW_AW-1:0] ram_addr;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic              item_acc;
  logic              res_free;
  logic [IDX_W-1:0]  lim;
  logic [IDX_W-1:0]  row_base;
  logic [WORD_W-1:0] seg_mask;
  logic [OFF_W-1:0]  cur_off;
  logic [OFF_W-1:0]  node_off;
  logic [IDX_W:0]    hi_dbl;
  logic              seg_last;
  logic              lvl_go;

  btm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_ram (
    .clk  (clk),
    .addr (ram_addr),
    .we   (ram_we),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign res_free   = !res_valid || !res_stall;

  // Subtree bound: node_limit clipped to the store
  assign lim = (IDX_W'(node_limit) < IDX_LIM) ? IDX_W'(node_limit) : IDX_LIM;

  // Mask of the bits in the current row that fall in [lo, seg_end]
  assign row_base = IDX_W'(row) << OFF_W;
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      seg_mask[b] = ((row_base + IDX_W'(b)) >= lo) && ((row_base + IDX_W'(b)) <= seg_end);
    end
  end

  assign cur_off  = cur[OFF_W-1:0];
  assign node_off = node_q[OFF_W-1:0];
  assign hi_dbl   = {hi, 1'b0} + (IDX_W+1)'(2);
  assign seg_last = (IDX_W'(row) == (seg_end >> OFF_W));
  assign lvl_go   = (step < level_count) && !(bucket > BUCKET_W'(req));

  // Next state and RAM control
  always_comb begin
    state_next = state;
    ram_addr   = row;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;
    case (state)
      ST_CLEAR: begin
        ram_addr  = clr_row;
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (clr_row == ROW_AW'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_acc) begin
          case (cmd_t'(command))
            CMD_ANCESTORS: state_next = ST_ANC_RD;
            CMD_SUBTREE:   state_next = ST_SUB_LEVEL;
            CMD_LEVEL:     state_next = ST_LVL;
            CMD_READ:      state_next = ST_BIT_RD;
            default:       state_next = ST_DONE;
          endcase
        end
      end
      ST_ANC_RD: begin
        ram_addr   = ROW_AW'(cur[IDX_W-1:OFF_W]);
        state_next = ST_ANC_WR;
      end
      ST_ANC_WR: begin
        ram_addr           = ROW_AW'(cur[IDX_W-1:OFF_W]);
        ram_we             = (cur < IDX_LIM);
        ram_wdata[cur_off] = status_q;
        state_next         = (cur == '0) ? ST_DONE : ST_ANC_RD;
      end
      ST_SUB_LEVEL: begin
        state_next = (lo < lim) ? ST_SUB_RD : ST_DONE;
      end
      ST_SUB_RD: begin
        state_next = ST_SUB_WR;
      end
      ST_SUB_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = (ram_rdata & ~seg_mask) | ({WORD_W{status_q}} & seg_mask);
        state_next = seg_last ? ST_SUB_LEVEL : ST_SUB_RD;
      end
      ST_LVL: begin
        if (!lvl_go) begin
          state_next = ST_DONE;
        end
      end
      ST_BIT_RD: begin
        ram_addr   = ROW_AW'(node_q[NODE_W-1:OFF_W]);
        state_next = ST_BIT_GET;
      end
      ST_BIT_GET: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count     <= RST_LEVEL_COUNT;
      start_level     <= RST_START_LEVEL;
      min_bucket_size <= RST_MIN_BUCKET;
      node_limit      <= RST_NODE_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEVEL_COUNT: level_count     <= cfg_data[4:0];
        CFG_START_LEVEL: start_level     <= cfg_data[3:0];
        CFG_MIN_BUCKET:  min_bucket_size <= cfg_data[20:0];
        CFG_NODE_LIMIT:  node_limit      <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == ST_CLEAR) begin
      clr_row <= clr_row + ROW_AW'(1);
    end
  end

  // Item latch and walk datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_acc) begin
          cmd      <= cmd_t'(command);
          node_q   <= node;
          status_q <= status;
          req      <= request_size;
          cur      <= IDX_W'(node);
          lo       <= IDX_W'(node);
          hi       <= IDX_W'(node);
          bucket   <= BUCKET_W'(min_bucket_size);
          lvl      <= signed'({1'b0, start_level});
          step     <= '0;
        end
      end
      ST_ANC_WR: begin
        // Step to the parent
        cur <= (cur - IDX_W'(1)) >> 1;
      end
      ST_SUB_LEVEL: begin
        seg_end <= (hi < lim - IDX_W'(1)) ? hi : lim - IDX_W'(1);
        row     <= ROW_AW'(lo[IDX_W-1:OFF_W]);
      end
      ST_SUB_WR: begin
        if (seg_last) begin
          // Descend one level: first and last child of the span
          lo <= IDX_W'({lo, 1'b1});
          hi <= (hi_dbl > (IDX_W+1)'(HI_CAP)) ? HI_CAP : hi_dbl[IDX_W-1:0];
        end else begin
          row <= row + ROW_AW'(1);
        end
      end
      ST_LVL: begin
        if (lvl_go) begin
          bucket <= (bucket > BUCKET_HALF) ? BUCKET_MAX : (bucket << 1);
          if (lvl != LEVEL_MIN) begin
            lvl <= lvl - 5'sd1;
          end
          step <= step + 5'd1;
        end
      end
      ST_BIT_GET: begin
        bit_q <= (IDX_W'(node_q) < IDX_LIM) ? ram_rdata[node_off] : 1'b0;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_DONE && res_free) begin
      level     <= (cmd == CMD_LEVEL) ? lvl : 5'sd0;
      bit_value <= (cmd == CMD_READ) ? bit_q : 1'b0;
      done_res  <= 1'b1;
    end
  end

endmodule

[dv/tb_buddy_tree_bitmap_marker_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for buddy_tree_bitmap_marker_top: directed table, then random
// command beats over several register settings, each result checked by table or predictor.
// Depends on btm_pkg and the RTL of the block.
module tb_buddy_tree_bitmap_marker_top;
  import btm_pkg::*;

  typedef struct packed {
    logic signed [4:0] level;
    logic              bit_value;
    logic              done;
  } outcome_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [9:0]        node;
    logic              status;
    logic [23:0]       req;
    logic              typed;
    logic signed [4:0] exp_level;
    logic              exp_bit;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = CFG_LEVEL_COUNT;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic [1:0]              command = CMD_READ;
  logic [NODE_W-1:0]       node = '0;
  logic                    status = 1'b0;
  logic [REQ_W-1:0]        request_size = '0;
  logic                    res_valid;
  logic                    res_stall = 1'b0;
  logic signed [4:0]       level;
  logic                    bit_value;
  logic                    done_res;

  // Predictor copy of the bitmap and the registers
  bit          tree_map [STORE_SIZE];
  logic [4:0]  lvl_count = RST_LEVEL_COUNT;
  logic [3:0]  start_lvl = RST_START_LEVEL;
  logic [20:0] min_bkt   = RST_MIN_BUCKET;
  logic [9:0]  node_lim  = RST_NODE_LIMIT;

  outcome_t  outcome_q[$];
  stim_row_t plan[$];
  int        fail_count = 0;
  int        results_seen = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        quiet = 1'b0;

  buddy_tree_bitmap_marker_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .command(command), .node(node),
    .status(status), .request_size(request_size),
    .res_valid(res_valid), .res_stall(res_stall), .level(level), .bit_value(bit_value),
    .done_res(done_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the bitmap copy and work out its result
  function automatic outcome_t run_command(cmd_t c, logic [9:0] nd, logic st, logic [23:0] rq);
    outcome_t    res;
    int          idx;
    int          lo;
    int          hi;
    int          lvl;
    logic [31:0] bucket;
    res = '{level: 5'sd0, bit_value: 1'b0, done: 1'b1};
    case (c)
      CMD_ANCESTORS: begin
        idx = nd;
        while (1) begin
          if (idx < STORE_SIZE) tree_map[idx] = st;
          if (idx == 0) break;
          idx = (idx - 1) / 2;
        end
      end
      CMD_SUBTREE: begin
        lo = nd;
        hi = nd;
        // Walk level by level; the node limit cuts each level short
        while (lo < node_lim && lo < STORE_SIZE) begin
          for (idx = lo; idx <= hi && idx < node_lim; idx++) tree_map[idx] = st;
          lo = 2 * lo + 1;
          hi = 2 * hi + 2;
        end
      end
      CMD_LEVEL: begin
        lvl = start_lvl;
        bucket = min_bkt;
        for (int i = 0; i < lvl_count; i++) begin
          if (bucket > rq) break;
          // Saturate the doubling at the 25-bit ceiling, floor the level at -16
          bucket = (bucket > 32'h0FF_FFFF) ? 32'h1FF_FFFF : bucket * 2;
          if (lvl > -16) lvl--;
        end
        res.level = lvl[4:0];
      end
      default: begin
        res.bit_value = (nd < STORE_SIZE) ? tree_map[nd] : 1'b0;
      end
    endcase
    return res;
  endfunction

  task automatic add_row(cmd_t c, logic [9:0] nd, logic st, logic [23:0] rq, logic typed,
                         logic signed [4:0] lvl, logic bv);
    stim_row_t r;
    r.cmd = c;
    r.node = nd;
    r.status = st;
    r.req = rq;
    r.typed = typed;
    r.exp_level = lvl;
    r.exp_bit = bv;
    plan.push_back(r);
  endtask

  // Offer one command beat, with an optional idle burst first
  task automatic send_item(cmd_t c, logic [9:0] nd, logic st, logic [23:0] rq,
                           logic typed, outcome_t fixed);
    outcome_t pred;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    command      <= c;
    node         <= nd;
    status       <= st;
    request_size <= rq;
    do @(posedge clk); while (item_stall);
    pred = run_command(c, nd, st, rq);
    outcome_q.push_back(typed ? fixed : pred);
  endtask

  task automatic send_random(int count);
    cmd_t        c;
    logic [9:0]  nd;
    logic [23:0] rq;
    int          roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      c = (roll < 20) ? CMD_ANCESTORS : (roll < 40) ? CMD_SUBTREE :
          (roll < 65) ? CMD_LEVEL : CMD_READ;
      nd = 10'($urandom_range(0, 1023));
      // Keep most subtree walks short; the rest may start at any node
      if (c == CMD_SUBTREE && $urandom_range(0, 3) != 0) nd = 10'($urandom_range(63, 1023));
      rq = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom >> $urandom_range(0, 31));
      send_item(c, nd, 1'($urandom_range(0, 1)), rq, 1'b0, '0);
    end
  endtask

  // Write one register; the caller drops cfg_valid after the last beat
  task automatic write_reg(cfg_idx_t idx, logic [20:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEVEL_COUNT: lvl_count = val[4:0];
      CFG_START_LEVEL: start_lvl = val[3:0];
      CFG_MIN_BUCKET:  min_bkt   = val;
      default:         node_lim  = val[9:0];
    endcase
  endtask

  // Drain, reprogram all registers, then run random beats
  task automatic run_phase(int lc, int sl, int mb, int nl, int count);
    item_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    write_reg(CFG_LEVEL_COUNT, 21'(lc));
    write_reg(CFG_START_LEVEL, 21'(sl));
    write_reg(CFG_MIN_BUCKET, 21'(mb));
    write_reg(CFG_NODE_LIMIT, 21'(nl));
    cfg_valid <= 1'b0;
    send_random(count);
  endtask

  task automatic flag(string what, outcome_t e);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: exp level %0d bit %0b done %0b, got level %0d bit %0b done %0b",
               $time, what, e.level, e.bit_value, e.done, level, bit_value, done_res);
  endtask

  // Check result beats and stall the result channel in bursts
  always @(posedge clk) begin
    outcome_t e;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          flag("unexpected result", '0);
        end else begin
          e = outcome_q.pop_front();
          if (level !== e.level || bit_value !== e.bit_value || done_res !== e.done)
            flag("mismatch", e);
        end
      end
      // Hold off once for a long stretch so the block backs up its input
      if (!hold_done && results_seen == 600) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    stim_row_t r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table under reset register values
    add_row(CMD_READ,      10'd0,    1'b0, 24'd0,        1'b1, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd1022, 1'b0, 24'hFFFFFF,   1'b1, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd1023, 1'b1, 24'd0,        1'b1, 5'sd0,  1'b0);
    add_row(CMD_LEVEL,     10'd0,    1'b0, 24'd0,        1'b1, 5'sd9,  1'b0);
    add_row(CMD_LEVEL,     10'd0,    1'b0, 24'd16,       1'b1, 5'sd8,  1'b0);
    add_row(CMD_LEVEL,     10'd1023, 1'b1, 24'hFFFFFF,   1'b1, -5'sd1, 1'b0);
    add_row(CMD_ANCESTORS, 10'd1022, 1'b1, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd1022, 1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd0,    1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_ANCESTORS, 10'd1023, 1'b1, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd511,  1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_SUBTREE,   10'd0,    1'b1, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd1021, 1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_SUBTREE,   10'd3,    1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd1000, 1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd7,    1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_ANCESTORS, 10'd0,    1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd0,    1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_SUBTREE,   10'd1022, 1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd1022, 1'b0, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_SUBTREE,   10'd1023, 1'b1, 24'd0,        1'b0, 5'sd0,  1'b0);
    add_row(CMD_READ,      10'd1023, 1'b0, 24'd0,        1'b1, 5'sd0,  1'b0);
    add_row(CMD_LEVEL,     10'd341,  1'b1, 24'hAAAAAA,   1'b0, 5'sd0,  1'b0);
    add_row(CMD_LEVEL,     10'd682,  1'b0, 24'h555555,   1'b0, 5'sd0,  1'b0);
    foreach (plan[i]) begin
      r = plan[i];
      send_item(r.cmd, r.node, r.status, r.req, r.typed,
                '{level: r.exp_level, bit_value: r.exp_bit, done: 1'b1});
    end
    send_random(300);

    // Extremes: zero search steps, zero node limit, widest bucket
    run_phase(0, 15, 21'h1FFFFF, 0, 150);
    // Zero bucket climbs every step and floors the level
    run_phase(31, 0, 0, 1, 150);
    run_phase(16, 15, 1, 1022, 250);
    run_phase($urandom_range(1, 16), $urandom_range(0, 15), $urandom_range(1, 1 << 20),
              $urandom_range(1, 1023), 250);
    run_phase(1, 7, 21'h100000, 500, 200);
    // Close out with no idling on either side
    quiet = 1'b1;
    run_phase(RST_LEVEL_COUNT, RST_START_LEVEL, RST_MIN_BUCKET, RST_NODE_LIMIT, 250);

    item_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("** buddy_tree_bitmap_marker_top: PASSED **");
    end else begin
      $display("** buddy_tree_bitmap_marker_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("** buddy_tree_bitmap_marker_top: FAILED **");
    $finish;
  end

endmodule
